// ----- src/sst_pkg.sv -----
// sst_pkg: request and result types, operation codes and control bundles
// for the shared segment table. No dependencies.
`timescale 1ns / 1ps

package sst_pkg;

   // operation codes carried in the func field
   localparam logic [2:0] FUNC_LOOKUP  = 3'd0;
   localparam logic [2:0] FUNC_CREATE  = 3'd1;
   localparam logic [2:0] FUNC_ATTACH  = 3'd2;
   localparam logic [2:0] FUNC_DETACH  = 3'd3;
   localparam logic [2:0] FUNC_DESTROY = 3'd4;

   // largest reference count, held there on attach
   localparam logic [15:0] REFS_MAX = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] key;
      logic [7:0]  seg_id;
      logic [31:0] seg_size;
      logic [31:0] region_addr;
      logic        region_ok;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  slot_out;
      logic [31:0] addr_out;
      logic [31:0] bytes_out;
      logic        region_taken;
      logic        free_request;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

   // status from the datapath back to the controller
   typedef struct packed {
      logic rsp_pending;
   } dp_status_type;

endpackage

// ----- src/sst_ctrl.sv -----
// sst_ctrl: request sequencer for the shared segment table.
// Depends on sst_pkg for the command and status bundles.
`timescale 1ns / 1ps

module sst_ctrl
   import sst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // a request enters only while idle
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   assign cmd.capture = accept;
   assign cmd.execute = (state_ff == ST_EXEC);

   // a result is shown only in the cycle right after execution
   assert property (@(posedge clock) disable iff (reset)
      status.rsp_pending |-> $past(state_ff == ST_EXEC))
      else $error("result strobe without a preceding execute cycle");

   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.execute)
      else $error("captured request was not executed next cycle");

   assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> !cmd.execute)
      else $error("execute held for more than one cycle");

endmodule

// ----- src/sst_datapath.sv -----
// sst_datapath: slot storage, parallel key compare, slot selection and
// result register of the shared segment table. Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_datapath
   import sst_pkg::*;
#(
   parameter int SEGMENTS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  req_type       req_data,
   output dp_status_type status,
   output logic          rsp_strobe,
   output rsp_type       rsp_data
);

   localparam int IDX_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int SLOT_W = (IDX_W > 4) ? IDX_W : 4;

   // lowest set bit of a slot vector
   function automatic logic [IDX_W-1:0] lowest(input logic [SEGMENTS-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = SEGMENTS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   // slot storage: valid bits and keys in flops, the rest in memories
   logic [SEGMENTS-1:0] valid_ff;
   logic [SEGMENTS-1:0] valid_in;
   logic [31:0]         key_ff [SEGMENTS];
   logic [31:0]         bytes_mem [SEGMENTS];
   logic [31:0]         base_mem [SEGMENTS];
   logic [15:0]         refs_mem [SEGMENTS];

   // captured request and first-cycle results
   req_type             req_ff;
   logic [SEGMENTS-1:0] match_ff;
   logic [SEGMENTS-1:0] match_in;
   logic [SEGMENTS-1:0] free_ff;
   logic                id_ok_ff;
   logic                id_ok_in;
   logic [IDX_W-1:0]    id_idx_ff;
   logic [IDX_W-1:0]    id_idx;
   logic [31:0]         bytes_rd_ff;
   logic [31:0]         base_rd_ff;
   logic [15:0]         refs_rd_ff;

   // result register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   // execute-cycle controls
   logic                match_any;
   logic                free_any;
   logic [IDX_W-1:0]    match_idx;
   logic [IDX_W-1:0]    free_idx;
   logic [SLOT_W-1:0]   slot_wide;
   logic [IDX_W-1:0]    slot_idx;
   logic [IDX_W-1:0]    wr_idx;
   logic                wr_new;
   logic                wr_refs;
   logic [15:0]         refs_wdata;
   logic                set_valid;
   logic                clr_valid;

   // key compare against every slot, straight from the request ports
   always_comb begin
      for (int i = 0; i < SEGMENTS; i++) begin
         match_in[i] = valid_ff[i] && (key_ff[i] == req_data.key);
      end
   end

   // slot number check for attach, detach and destroy
   assign id_idx   = req_data.seg_id[IDX_W-1:0];
   assign id_ok_in = (32'(req_data.seg_id) < SEGMENTS) && valid_ff[id_idx];

   // capture stage
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff      <= req_data;
         match_ff    <= match_in;
         free_ff     <= ~valid_ff;
         id_ok_ff    <= id_ok_in;
         id_idx_ff   <= id_idx;
         bytes_rd_ff <= bytes_mem[id_idx];
         base_rd_ff  <= base_mem[id_idx];
         refs_rd_ff  <= refs_mem[id_idx];
      end
   end

   // slot selection
   assign match_any = |match_ff;
   assign free_any  = |free_ff;
   assign match_idx = lowest(match_ff);
   assign free_idx  = lowest(free_ff);

   // operation decode and result
   always_comb begin
      rsp_in     = '0;
      slot_idx   = '0;
      wr_idx     = id_idx_ff;
      wr_new     = 1'b0;
      wr_refs    = 1'b0;
      refs_wdata = refs_rd_ff;
      set_valid  = 1'b0;
      clr_valid  = 1'b0;
      case (req_ff.func)
         FUNC_LOOKUP: begin
            if (match_any) begin
               rsp_in.ok = 1'b1;
               slot_idx  = match_idx;
            end
         end
         FUNC_CREATE: begin
            if (req_ff.seg_size != '0) begin
               if (match_any) begin
                  rsp_in.ok = 1'b1;
                  slot_idx  = match_idx;
               end else if (free_any && req_ff.region_ok) begin
                  rsp_in.ok           = 1'b1;
                  rsp_in.region_taken = 1'b1;
                  slot_idx            = free_idx;
                  wr_idx              = free_idx;
                  wr_new              = 1'b1;
                  wr_refs             = 1'b1;
                  refs_wdata          = '0;
                  set_valid           = 1'b1;
               end
            end
         end
         FUNC_ATTACH: begin
            if (id_ok_ff) begin
               rsp_in.ok        = 1'b1;
               rsp_in.addr_out  = base_rd_ff;
               rsp_in.bytes_out = bytes_rd_ff;
               wr_refs          = 1'b1;
               if (refs_rd_ff != REFS_MAX) begin
                  refs_wdata = refs_rd_ff + 16'd1;
               end
            end
         end
         FUNC_DETACH: begin
            if (id_ok_ff) begin
               rsp_in.ok = 1'b1;
               wr_refs   = 1'b1;
               if (refs_rd_ff != '0) begin
                  refs_wdata = refs_rd_ff - 16'd1;
               end
            end
         end
         FUNC_DESTROY: begin
            if (id_ok_ff && (refs_rd_ff == '0)) begin
               rsp_in.ok           = 1'b1;
               rsp_in.addr_out     = base_rd_ff;
               rsp_in.bytes_out    = bytes_rd_ff;
               rsp_in.free_request = 1'b1;
               clr_valid           = 1'b1;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
      slot_wide       = SLOT_W'(slot_idx);
      rsp_in.slot_out = slot_wide[3:0];
   end

   // valid bit update
   always_comb begin
      valid_in = valid_ff;
      if (cmd.execute && set_valid) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (cmd.execute && clr_valid) begin
         valid_in[wr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // slot memories, written in the execute cycle
   always_ff @(posedge clock) begin
      if (cmd.execute && wr_new) begin
         key_ff[wr_idx]    <= req_ff.key;
         bytes_mem[wr_idx] <= req_ff.seg_size;
         base_mem[wr_idx]  <= req_ff.region_addr;
      end
      if (cmd.execute && wr_refs) begin
         refs_mem[wr_idx] <= refs_wdata;
      end
   end

   // result register, shown for one cycle
   assign rsp_valid_in = cmd.execute;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_data           = rsp_ff;
   assign status.rsp_pending = rsp_valid_ff;

   // a claimed region always means a successful create
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.region_taken) |-> (rsp_ff.ok && !rsp_ff.free_request))
      else $error("region taken on a failed or destroying request");

   // create only claims a slot that was free when the request was captured
   assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && set_valid) |-> !valid_ff[wr_idx])
      else $error("create claimed a slot that is already in use");

   // destroy frees a slot that was in use
   assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && clr_valid) |=> !valid_ff[$past(wr_idx)])
      else $error("destroyed slot still marked in use");

endmodule

// ----- src/shared_segment_table.sv -----
// shared_segment_table: top level of the shared-memory segment table.
// Depends on sst_pkg, sst_ctrl and sst_datapath.
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low. In
// the accept cycle the key is compared against every slot at once and
// the slot memories are read at seg_id; in the following cycle the lowest
// matching or free slot is picked and the table is updated. busy is high
// for that one cycle. The result appears on rsp_data with rsp_strobe high
// for exactly one cycle, the cycle after the update; it is shown only
// once and cannot be held off, so the receiver must take it then. A new
// request may be started in the same cycle the result is shown. No
// clearing pass is needed after reset.

module shared_segment_table
   import sst_pkg::*;
#(
   parameter int SEGMENTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // request sequencing
   sst_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // slot table and result register
   sst_datapath #(
      .SEGMENTS (SEGMENTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for the shared segment table. It drives
// requests from a queue and checks every result against its own table model.
// Depends on sst_pkg and shared_segment_table.
`timescale 1ns / 1ps

module tb_top;
   import sst_pkg::*;

   localparam int NUM_SLOTS = 16;

   // one queued request and whether the sender waits for all results first
   typedef struct {
      req_type req;
      bit      drain_first;
   } backlog_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   backlog_type req_backlog[$];
   rsp_type     pending_results[$];
   int          in_flight = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          error_count = 0;

   // segment table as the block should hold it
   bit          seg_valid[NUM_SLOTS];
   logic [31:0] seg_key[NUM_SLOTS];
   logic [31:0] seg_bytes[NUM_SLOTS];
   logic [31:0] seg_base[NUM_SLOTS];
   logic [15:0] seg_refs[NUM_SLOTS];

   logic [31:0] key_pool[24];

   shared_segment_table #(
      .SEGMENTS(NUM_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // lowest valid slot holding the key, NUM_SLOTS if none
   function automatic int find_segment(input logic [31:0] k);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (seg_valid[i] && seg_key[i] == k)
            return i;
      end
      return NUM_SLOTS;
   endfunction

   // apply one request to the table and return the result it must produce
   function automatic rsp_type apply_segment_op(input req_type r);
      rsp_type o;
      int      s;
      int      held;
      o = '0;
      held = (r.seg_id < NUM_SLOTS && seg_valid[r.seg_id]) ? int'(r.seg_id) : NUM_SLOTS;
      case (r.func)
         FUNC_LOOKUP: begin
            s = find_segment(r.key);
            if (s < NUM_SLOTS) begin
               o.ok = 1'b1;
               o.slot_out = s[3:0];
            end
         end
         FUNC_CREATE: begin
            if (r.seg_size != 32'd0) begin
               s = find_segment(r.key);
               if (s < NUM_SLOTS) begin
                  o.ok = 1'b1;
                  o.slot_out = s[3:0];
               end else begin
                  s = 0;
                  while (s < NUM_SLOTS && seg_valid[s])
                     s++;
                  if (s < NUM_SLOTS && r.region_ok) begin
                     seg_valid[s] = 1'b1;
                     seg_key[s] = r.key;
                     seg_bytes[s] = r.seg_size;
                     seg_base[s] = r.region_addr;
                     seg_refs[s] = '0;
                     o.ok = 1'b1;
                     o.slot_out = s[3:0];
                     o.region_taken = 1'b1;
                  end
               end
            end
         end
         FUNC_ATTACH: begin
            if (held < NUM_SLOTS) begin
               if (seg_refs[held] != REFS_MAX)
                  seg_refs[held] = seg_refs[held] + 16'd1;
               o.ok = 1'b1;
               o.addr_out = seg_base[held];
               o.bytes_out = seg_bytes[held];
            end
         end
         FUNC_DETACH: begin
            if (held < NUM_SLOTS) begin
               if (seg_refs[held] != 16'd0)
                  seg_refs[held] = seg_refs[held] - 16'd1;
               o.ok = 1'b1;
            end
         end
         FUNC_DESTROY: begin
            if (held < NUM_SLOTS && seg_refs[held] == 16'd0) begin
               o.addr_out = seg_base[held];
               o.bytes_out = seg_bytes[held];
               seg_valid[held] = 1'b0;
               seg_refs[held] = '0;
               o.ok = 1'b1;
               o.free_request = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   task automatic queue_req(input logic [2:0] f, input logic [31:0] k, input logic [7:0] id,
                            input logic [31:0] sz, input logic [31:0] ad, input logic rok,
                            input bit drain);
      backlog_type b;
      b.req.func = f;
      b.req.key = k;
      b.req.seg_id = id;
      b.req.seg_size = sz;
      b.req.region_addr = ad;
      b.req.region_ok = rok;
      b.drain_first = drain;
      req_backlog.push_back(b);
   endtask

   // request driver: bursts of requests with random gaps between them
   always @(posedge clock) begin
      backlog_type nxt;
      bit          took;
      if (reset) begin
         start <= 1'b0;
         in_flight = 0;
         burst_left = $urandom_range(1, 16);
         gap_left = 0;
      end else begin
         took = start && !busy;
         if (took)
            in_flight++;
         if (rsp_strobe)
            in_flight--;
         if (took) begin
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (took || !start) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (req_backlog.size() > 0 &&
                         !(req_backlog[0].drain_first && in_flight > 0)) begin
               nxt = req_backlog.pop_front();
               req_data <= nxt.req;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // result monitor: predict on each taken request, check each strobe
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            seg_valid[i] = 1'b0;
            seg_key[i] = '0;
            seg_bytes[i] = '0;
            seg_base[i] = '0;
            seg_refs[i] = '0;
         end
         pending_results.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: result with no request waiting: %p", $realtime, rsp_data);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.ok !== want.ok || rsp_data.slot_out !== want.slot_out ||
                   rsp_data.addr_out !== want.addr_out ||
                   rsp_data.bytes_out !== want.bytes_out ||
                   rsp_data.region_taken !== want.region_taken ||
                   rsp_data.free_request !== want.free_request) begin
                  if (error_count < 10)
                     $display("%0t: wrong result: expected %p, got %p",
                              $realtime, want, rsp_data);
                  error_count++;
               end
            end
         end
         if (start && !busy)
            pending_results.push_back(apply_segment_op(req_data));
      end
   end

   // stimulus and end of run
   initial begin
      int          roll;
      int          mode;
      logic [2:0]  f;
      logic [31:0] k;
      logic [7:0]  id;
      logic [31:0] sz;

      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 24; i++)
         key_pool[i] = $urandom;

      // directed: empty table, bad sizes, refused region, known key
      queue_req(FUNC_LOOKUP, 32'h0, 8'd0, 32'd1, 32'h0, 1'b1, 1'b0);
      queue_req(FUNC_CREATE, 32'hFFFF_FFFF, 8'd0, 32'd0, 32'h10, 1'b1, 1'b0);
      queue_req(FUNC_CREATE, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_req(FUNC_CREATE, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
      queue_req(FUNC_CREATE, 32'h0, 8'hFF, 32'd1, 32'h0, 1'b1, 1'b0);
      queue_req(FUNC_CREATE, 32'hFFFF_FFFF, 8'd0, 32'd5, 32'h123, 1'b1, 1'b0);
      queue_req(FUNC_CREATE, 32'hFFFF_FFFF, 8'd0, 32'd0, 32'h123, 1'b1, 1'b0);
      queue_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 8'd0, 32'd0, 32'h0, 1'b0, 1'b0);
      queue_req(FUNC_LOOKUP, 32'h0, 8'd0, 32'd0, 32'h0, 1'b0, 1'b0);
      // attach, out of range and empty slots, destroy while attached
      queue_req(FUNC_ATTACH, 32'h0, 8'd0, 32'd0, 32'h0, 1'b0, 1'b0);
      queue_req(FUNC_ATTACH, 32'h0, 8'hFF, 32'd0, 32'h0, 1'b0, 1'b0);
      queue_req(FUNC_ATTACH, 32'h0, 8'd16, 32'd0, 32'h0, 1'b0, 1'b0);
      queue_req(FUNC_ATTACH, 32'h0, 8'd7, 32'd0, 32'h0, 1'b0, 1'b0);
      queue_req(FUNC_DESTROY, 32'h0, 8'd0, 32'd0, 32'h0, 1'b0, 1'b0);
      // detach down to zero and once more at zero, then destroy
      queue_req(FUNC_DETACH, 32'h0, 8'd0, 32'd0, 32'h0, 1'b0, 1'b0);
      queue_req(FUNC_DETACH, 32'h0, 8'd0, 32'd0, 32'h0, 1'b0, 1'b0);
      queue_req(FUNC_DESTROY, 32'h0, 8'd0, 32'd0, 32'h0, 1'b0, 1'b1);
      queue_req(FUNC_DESTROY, 32'h0, 8'd0, 32'd0, 32'h0, 1'b0, 1'b0);
      queue_req(FUNC_DETACH, 32'h0, 8'd0, 32'd0, 32'h0, 1'b0, 1'b0);
      // freed slot is reused, a new segment starts unattached
      queue_req(FUNC_CREATE, 32'hA5A5_A5A5, 8'd0, 32'h80, 32'h1000, 1'b1, 1'b0);
      queue_req(FUNC_DESTROY, 32'h0, 8'd0, 32'd0, 32'h0, 1'b0, 1'b0);
      queue_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 8'd0, 32'd0, 32'h0, 1'b0, 1'b0);
      // unknown operations
      for (int c = 5; c < 8; c++)
         queue_req(c[2:0], $urandom, 8'($urandom), $urandom, $urandom, 1'($urandom), 1'b0);

      // slot 1: detach at zero, attach twice, destroy while attached
      queue_req(FUNC_DETACH, 32'h0, 8'd1, 32'd0, 32'h0, 1'b0, 1'b1);
      queue_req(FUNC_ATTACH, 32'h0, 8'd1, 32'd0, 32'h0, 1'b0, 1'b0);
      queue_req(FUNC_ATTACH, 32'h0, 8'd1, 32'd0, 32'h0, 1'b0, 1'b0);
      queue_req(FUNC_DESTROY, 32'h0, 8'd1, 32'd0, 32'h0, 1'b0, 1'b0);

      // random: alternate between filling and tearing down the table
      for (int n = 0; n < 800; n++) begin
         mode = (n / 100) % 2;
         roll = $urandom_range(0, 99);
         if (roll < 2)
            f = 3'd5 + 3'($urandom_range(0, 2));
         else if (roll < (mode == 0 ? 42 : 12))
            f = FUNC_CREATE;
         else if (roll < (mode == 0 ? 57 : 27))
            f = FUNC_LOOKUP;
         else if (roll < (mode == 0 ? 77 : 37))
            f = FUNC_ATTACH;
         else if (roll < (mode == 0 ? 92 : 72))
            f = FUNC_DETACH;
         else
            f = FUNC_DESTROY;
         k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 23)] : $urandom;
         id = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, NUM_SLOTS - 1)) :
                                             8'($urandom_range(NUM_SLOTS, 255));
         roll = $urandom_range(0, 99);
         sz = (roll < 5) ? 32'd0 : (roll < 15) ? 32'hFFFF_FFFF : $urandom;
         queue_req(f, k, id, sz, $urandom, $urandom_range(0, 9) != 0,
                   $urandom_range(0, 49) == 0);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // wait for the backlog to drain and every result to return
      do
         @(negedge clock);
      while (req_backlog.size() != 0 || start || in_flight != 0);
      repeat (6) @(negedge clock);

      if (pending_results.size() != 0) begin
         $display("%0d results never arrived", pending_results.size());
         error_count++;
      end
      if (error_count == 0)
         $display("shared_segment_table: match");
      else
         $display("shared_segment_table: mismatch");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("shared_segment_table: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
src/sst_pkg.sv
src/sst_ctrl.sv
src/sst_datapath.sv
src/shared_segment_table.sv
tb/tb_top.sv
